[hw/rtl/rowt_pkg.sv]
package rowt_pkg;

   localparam int OP_W   = 2;
   localparam int ADDR_W = 48;
   localparam int LEN_W  = 32;
   localparam int CNT_W  = 5;

   // counts stop here when the table holds more entries than fit
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_CHECK      = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic load;
      logic issue;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_issue;
      logic out_free;
   } ctl_sts_type;

endpackage

[hw/rtl/rowt_if.sv]
interface rowt_req_if;
   import rowt_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] addr;
   logic [LEN_W-1:0]  length;
   logic [LEN_W-1:0]  count;

   modport source (output valid, output op, output addr, output length, output count,
                   input ready);
   modport sink (input valid, input op, input addr, input length, input count,
                 output ready);
endinterface

interface rowt_rsp_if;
   import rowt_pkg::*;

   logic             valid;
   logic             ready;
   logic             hit;
   logic [CNT_W-1:0] hit_count;
   logic [CNT_W-1:0] removed_count;
   logic             table_full;

   modport source (output valid, output hit, output hit_count, output removed_count,
                   output table_full, input ready);
   modport sink (input valid, input hit, input hit_count, input removed_count,
                 input table_full, output ready);
endinterface

[hw/rtl/rowt_ctrl.sv]
module rowt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  rowt_pkg::ctl_sts_type sts,
   output rowt_pkg::ctl_cmd_type cmd
);
   import rowt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sts.last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load      = req_valid;
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_DONE: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hw/rtl/rowt_datapath.sv]
module rowt_datapath #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rowt_pkg::ctl_cmd_type         cmd,
   output rowt_pkg::ctl_sts_type         sts,
   input  logic [rowt_pkg::OP_W-1:0]     req_op,
   input  logic [rowt_pkg::ADDR_W-1:0]   req_addr,
   input  logic [rowt_pkg::LEN_W-1:0]    req_length,
   input  logic [rowt_pkg::LEN_W-1:0]    req_count,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [rowt_pkg::CNT_W-1:0]    rsp_hit_count,
   output logic [rowt_pkg::CNT_W-1:0]    rsp_removed_count,
   output logic                          rsp_table_full
);
   import rowt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   // ends are one bit wider than the wider of address and size
   localparam int SW = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

   logic [ADDR_BITS-1:0] start_mem [ENTRIES];
   logic [LEN_W-1:0]     len_mem   [ENTRIES];

   logic [ENTRIES-1:0]   valid_ff;
   op_type               op_ff;
   logic [ADDR_BITS-1:0] a_ff;
   logic [SW-1:0]        a_end_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic                 eval_vld_ff;
   logic [IW-1:0]        eval_idx_ff;
   logic [ADDR_BITS-1:0] rd_start_ff;
   logic [LEN_W-1:0]     rd_len_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 free_found_ff;
   logic [IW-1:0]        free_idx_ff;
   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic [CNT_W-1:0]     hit_count_ff;
   logic [CNT_W-1:0]     removed_ff;
   logic                 full_ff;

   logic [ADDR_BITS-1:0] a_in;
   logic [LEN_W-1:0]     n_in;
   logic [SW-1:0]        s_end;
   logic                 overlap;
   logic                 match;
   logic                 ent_valid;
   logic                 count_up;

   always_comb begin
      a_in         = '0;
      a_in[UW-1:0] = req_addr[UW-1:0];
      n_in         = (req_length < req_count) ? req_length : req_count;
   end

   assign ent_valid = valid_ff[eval_idx_ff];
   assign s_end     = SW'(rd_start_ff) + SW'(rd_len_ff);
   assign overlap   = !((a_end_ff <= SW'(rd_start_ff)) || (s_end <= SW'(a_ff)));
   assign match     = (rd_start_ff == a_ff);

   always_comb begin
      count_up = 1'b0;
      if (eval_vld_ff && ent_valid) begin
         case (op_ff)
            OP_UNREGISTER: count_up = match;
            OP_CHECK:      count_up = overlap;
            default:       count_up = 1'b0;
         endcase
      end
   end

   assign sts.last_issue = (rd_idx_ff == IW'(ENTRIES - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // table storage: registered read during the walk, write on finish
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_start_ff <= start_mem[rd_idx_ff];
         rd_len_ff   <= len_mem[rd_idx_ff];
      end
      if (cmd.finish && op_ff == OP_REGISTER && free_found_ff) begin
         start_mem[free_idx_ff] <= a_ff;
         len_mem[free_idx_ff]   <= a_end_ff[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         a_ff     <= a_in;
         // register keeps the range length, check and unregister keep the end of the clipped write
         if (op_type'(req_op) == OP_REGISTER) begin
            a_end_ff <= SW'(req_length);
         end else begin
            a_end_ff <= SW'(a_in) + SW'(n_in);
         end
      end
      eval_idx_ff <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_idx_ff     <= '0;
         eval_vld_ff   <= 1'b0;
         cnt_ff        <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eval_vld_ff <= cmd.issue;
         if (cmd.load) begin
            rd_idx_ff     <= '0;
            cnt_ff        <= '0;
            free_found_ff <= 1'b0;
         end else if (cmd.issue && !sts.last_issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (count_up && cnt_ff != CNT_MAX) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (eval_vld_ff && !ent_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx_ff;
         end
         if (eval_vld_ff && op_ff == OP_UNREGISTER && ent_valid && match) begin
            valid_ff[eval_idx_ff] <= 1'b0;
         end
         if (cmd.finish && op_ff == OP_REGISTER && free_found_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // fields that do not belong to the op read as zero
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         hit_ff       <= (op_ff == OP_CHECK) && (cnt_ff != '0);
         hit_count_ff <= (op_ff == OP_CHECK) ? cnt_ff : '0;
         removed_ff   <= (op_ff == OP_UNREGISTER) ? cnt_ff : '0;
         full_ff      <= (op_ff == OP_REGISTER) && !free_found_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_hit_count     = hit_count_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_table_full    = full_ff;

`ifndef SYNTHESIS
   a_one_add: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= $countones($past(valid_ff)) + 1)
      else $error("more than one entry added in a cycle");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && op_ff == OP_REGISTER && !free_found_ff) |-> (&valid_ff))
      else $error("register dropped while a slot was free");

   a_finish_after_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!eval_vld_ff && !cmd.issue))
      else $error("result taken before the walk drained");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> !cmd.load)
      else $error("request loaded during a walk");
`endif

endmodule

[hw/rtl/region_overlap_watch_table.sv]
// Each request is accepted in the idle state, then the table walk reads one entry a cycle from
// the single-port entry memory, then a drain state and a result state follow; the result state
// waits for a free output register. The next request is taken only once the response is posted.
// A new request is taken while the previous response still waits in the output register.
// Reset (synchronous, active high) clears all entry valid bits and the control state;
// entry storage itself is not cleared and needs no sweep.
module region_overlap_watch_table #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 48
) (
   input logic          clock,
   input logic          reset,
   rowt_req_if.sink     req_bus,
   rowt_rsp_if.source   rsp_bus
);
   import rowt_pkg::*;

   // controller <-> datapath
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign req_bus.ready = cmd.req_ready;

   // sequencer: idle -> walk every slot -> drain the read pipe -> post the response
   rowt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entry memory, valid bits, overlap/match compare, counters and the response register
   rowt_datapath #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_bus.op),
      .req_addr          (req_bus.addr),
      .req_length        (req_bus.length),
      .req_count         (req_bus.count),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_hit           (rsp_bus.hit),
      .rsp_hit_count     (rsp_bus.hit_count),
      .rsp_removed_count (rsp_bus.removed_count),
      .rsp_table_full    (rsp_bus.table_full)
   );

endmodule
